// File: rtl/dip_pkg.sv
// ============================================================================
// dip_pkg
// Shared types and constants for the decimal integer parser.
// ============================================================================
`default_nettype none

package dip_pkg;

  // Character codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Number formats selected by result_kind
  localparam logic [1:0] KIND_S64 = 2'd0;
  localparam logic [1:0] KIND_S32 = 2'd1;
  localparam logic [1:0] KIND_U64 = 2'd2;

  // Configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CFG_AW-1:0] ADDR_RESULT_KIND = 3'd0;

  localparam int unsigned VAL_W = 64;
  localparam int unsigned ACC_X_W = VAL_W + 4;   // room for acc * 10 + 9

  typedef enum logic [1:0] {
    FAIL_NONE     = 2'd0,
    FAIL_EMPTY    = 2'd1,
    FAIL_NONDIGIT = 2'd2,
    FAIL_RANGE    = 2'd3
  } fail_t;

  // State of one finished string, handed to the output stage
  typedef struct packed {
    logic [VAL_W-1:0] acc;
    logic             neg;
    logic             saw_digit;
    fail_t            code;
    logic [1:0]       kind;
  } fin_t;

endpackage

`default_nettype wire

// File: rtl/dip_step.sv
// ============================================================================
// dip_step
// Per-character state update: sign, digit accumulate with limit check,
// sticky failure. Registers the record of each finished string.
// ============================================================================
`default_nettype none

module dip_step (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         item_valid,
  input  wire logic [7:0]   item_char,
  input  wire logic         item_last,
  input  wire logic         item_empty,
  input  wire logic [1:0]   kind,
  input  wire logic         fin_ready,
  output logic              item_take,
  output logic              fin_valid,
  output dip_pkg::fin_t     fin
);
  import dip_pkg::*;

  logic [VAL_W-1:0]   acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic               start_r, start_nxt;
  logic               saw_r, saw_nxt;
  fail_t              code_r, code_nxt;
  logic               fin_valid_r, fin_valid_nxt;
  fin_t               fin_r, fin_nxt;

  logic               uns;
  logic               is_sign;
  logic               is_digit;
  logic [3:0]         digit;
  logic [ACC_X_W-1:0] acc_x;
  logic [ACC_X_W-1:0] sum;
  logic [ACC_X_W-1:0] limit;
  logic               ends;

  assign uns      = kind[1];
  assign is_sign  = (item_char == CH_MINUS) || (item_char == CH_PLUS);
  assign is_digit = (item_char >= CH_ZERO) && (item_char <= CH_NINE);
  assign digit    = 4'(item_char - CH_ZERO);
  assign acc_x    = {4'b0, acc_r};
  assign sum      = (acc_x << 3) + (acc_x << 1) + {{(ACC_X_W-4){1'b0}}, digit};
  assign ends     = item_empty || item_last;

  always_comb begin
    if (uns) begin
      limit = {4'b0, {VAL_W{1'b1}}};
    end else if (neg_r) begin
      limit = {4'b0, 1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      limit = {5'b0, {(VAL_W-1){1'b1}}};
    end
  end

  assign item_take = item_valid && (!fin_valid_r || fin_ready);

  always_comb begin
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    start_nxt     = start_r;
    saw_nxt       = saw_r;
    code_nxt      = code_r;
    fin_nxt       = fin_r;
    fin_valid_nxt = fin_valid_r && !fin_ready;

    if (item_take) begin
      if (!item_empty) begin
        start_nxt = 1'b0;
        if (code_r == FAIL_NONE) begin
          if (start_r && !uns && is_sign) begin
            neg_nxt = (item_char == CH_MINUS);
          end else if (!is_digit) begin
            code_nxt = FAIL_NONDIGIT;
          end else if (sum > limit) begin
            code_nxt = FAIL_RANGE;
          end else begin
            acc_nxt = sum[VAL_W-1:0];
            saw_nxt = 1'b1;
          end
        end
      end

      if (ends) begin
        // Hand off the string and start clean for the next one
        fin_nxt.acc       = acc_nxt;
        fin_nxt.neg       = neg_nxt;
        fin_nxt.saw_digit = saw_nxt;
        fin_nxt.code      = code_nxt;
        fin_nxt.kind      = kind;
        fin_valid_nxt     = 1'b1;
        acc_nxt           = '0;
        neg_nxt           = 1'b0;
        start_nxt         = 1'b1;
        saw_nxt           = 1'b0;
        code_nxt          = FAIL_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      neg_r       <= 1'b0;
      start_r     <= 1'b1;
      saw_r       <= 1'b0;
      code_r      <= FAIL_NONE;
      fin_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      start_r     <= start_nxt;
      saw_r       <= saw_nxt;
      code_r      <= code_nxt;
      fin_valid_r <= fin_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
  end

  assign fin_valid = fin_valid_r;
  assign fin       = fin_r;

endmodule

`default_nettype wire

// File: rtl/dip_finish.sv
// ============================================================================
// dip_finish
// Final sign apply, empty and 32-bit range checks; holds the result register.
// ============================================================================
`default_nettype none

module dip_finish (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fin_valid,
  input  wire dip_pkg::fin_t   fin,
  output logic                 fin_ready,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output logic [63:0]          res_value,
  output logic                 res_ok,
  output logic [1:0]           res_reason
);
  import dip_pkg::*;

  logic             valid_r, valid_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  fail_t            reason_r, reason_nxt;

  fail_t            code;
  logic [VAL_W-1:0] signed_val;
  logic [VAL_W-1:0] lim32;

  assign fin_ready = !valid_r || !res_stall;

  assign signed_val = fin.neg ? (VAL_W'(0) - fin.acc) : fin.acc;
  assign lim32 = fin.neg ? VAL_W'(64'h0000_0000_8000_0000)
                         : VAL_W'(64'h0000_0000_7FFF_FFFF);

  always_comb begin
    code = fin.code;
    if ((code == FAIL_NONE) && !fin.saw_digit) begin
      code = FAIL_EMPTY;
    end
    if ((code == FAIL_NONE) && (fin.kind == KIND_S32) && (fin.acc > lim32)) begin
      code = FAIL_RANGE;
    end
  end

  always_comb begin
    valid_nxt  = valid_r && res_stall;
    value_nxt  = value_r;
    reason_nxt = reason_r;
    if (fin_ready && fin_valid) begin
      valid_nxt  = 1'b1;
      reason_nxt = code;
      if (code != FAIL_NONE) begin
        value_nxt = '0;
      end else if (fin.kind[1]) begin
        value_nxt = fin.acc;
      end else begin
        value_nxt = signed_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    reason_r <= reason_nxt;
  end

  assign res_valid  = valid_r;
  assign res_value  = value_r;
  assign res_ok     = (reason_r == FAIL_NONE);
  assign res_reason = reason_r;

endmodule

`default_nettype wire

// File: rtl/decimal_integer_parser.sv
// ============================================================================
// decimal_integer_parser
// Streams ASCII decimal strings one byte per transfer and returns one result
// per string: the value as a 64-bit pattern plus ok and a failure reason.
// ============================================================================
// Path: the byte that ends a string passes through the input register, then
//   the state update and its finished-string register, then the result register.
// Throughput: one byte per cycle; the accumulate (acc * 10 + digit with limit
//   compare) is combinational on the state registers. A stalled result
//   register holds back the input once a second finished string waits.
// Reset: synchronous, active low; clears all valids, the string state and
//   result_kind (signed 64-bit).
`default_nettype none

module decimal_integer_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Input channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_char_code,
  input  wire logic                      in_is_last,
  input  wire logic                      in_is_empty,
  // Result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [63:0]                    out_value_bits,
  output logic                           out_ok,
  output logic [1:0]                     out_fail_reason,
  // Configuration port
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [dip_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [dip_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [dip_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready
);
  import dip_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration: a single register, result_kind, at addresses 0 to 3.
  // --------------------------------------------------------------------------
  logic [1:0] kind_r, kind_nxt;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    kind_nxt = kind_r;
    if (cfg_wr && (cfg_paddr[CFG_AW-1] == ADDR_RESULT_KIND[CFG_AW-1])) begin
      kind_nxt = cfg_pwdata[1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_AW-1] == ADDR_RESULT_KIND[CFG_AW-1]) begin
      cfg_prdata = {{(CFG_DW-2){1'b0}}, kind_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_S64;
    end else begin
      kind_r <= kind_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Input register. Hold the byte until the step stage takes it; the step
  // stage refuses any byte while a finished string is still waiting on a
  // stalled result register, otherwise bytes keep flowing every cycle.
  // --------------------------------------------------------------------------
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r, s1_char_nxt;
  logic       s1_last_r, s1_last_nxt;
  logic       s1_empty_r, s1_empty_nxt;
  logic       s1_take;
  logic       in_xfer;

  assign in_stall = s1_valid_r && !s1_take;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r && !s1_take;
    s1_char_nxt  = s1_char_r;
    s1_last_nxt  = s1_last_r;
    s1_empty_nxt = s1_empty_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
      s1_char_nxt  = in_char_code;
      s1_last_nxt  = in_is_last;
      s1_empty_nxt = in_is_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_char_r  <= s1_char_nxt;
    s1_last_r  <= s1_last_nxt;
    s1_empty_r <= s1_empty_nxt;
  end

  // --------------------------------------------------------------------------
  // Step stage: string state and the record of each finished string.
  // --------------------------------------------------------------------------
  logic fin_valid;
  logic fin_ready;
  fin_t fin;

  dip_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item_char  (s1_char_r),
    .item_last  (s1_last_r),
    .item_empty (s1_empty_r),
    .kind       (kind_r),
    .fin_ready  (fin_ready),
    .item_take  (s1_take),
    .fin_valid  (fin_valid),
    .fin        (fin)
  );

  // --------------------------------------------------------------------------
  // Finish stage: apply sign and range checks, drive the result register.
  // --------------------------------------------------------------------------
  dip_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .fin_valid  (fin_valid),
    .fin        (fin),
    .fin_ready  (fin_ready),
    .res_valid  (out_valid),
    .res_stall  (out_stall),
    .res_value  (out_value_bits),
    .res_ok     (out_ok),
    .res_reason (out_fail_reason)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A failed result always carries a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_value_bits == 64'd0))
    else $error("failed result carries a nonzero value");

  // ok and the failure reason agree.
  a_ok_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ok == (out_fail_reason == FAIL_NONE)))
    else $error("ok disagrees with failure reason");

  // An empty input register never pushes back.
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

  // A pending finished string is not dropped while the result register waits.
  a_fin_held: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_valid && out_valid && out_stall) |=> fin_valid)
    else $error("finished string lost under output stall");

endmodule

`default_nettype wire
